// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SRTI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SRTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/srti_pkg.sv =====
// ----------------------------------------------------------------------------
// srti_pkg: shared types and codes of the sorted region table
// Region record, per-cell control and outcome codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srti_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int FIELD_W   = 7;

	localparam logic [1:0] OUTCOME_INSERTED  = 2'd0;
	localparam logic [1:0] OUTCOME_DUPLICATE = 2'd1;
	localparam logic [1:0] OUTCOME_FULL      = 2'd2;

	typedef struct packed {
		logic [63:0] addr;
		logic [63:0] size;
	} region_t;

	typedef struct packed {
		logic cmp;    // capture compare flags against key
		logic ins;    // commit insert, shift if at or above slot
		logic valid;  // cell holds a live entry
	} srti_ctl_t;

endpackage

// ===== rtl/sorted_region_table_insert.sv =====
// ----------------------------------------------------------------------------
// sorted_region_table_insert: sorted region table with duplicate drop
// An accepted item is compared by the cell row, then shifted/committed while
// busy_q is set, which loads the result; no new item enters during the commit.
// Reset clears fill count and handshake state; table contents need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_region_table_insert
	import srti_pkg::*;
#(
	parameter int TABLE_DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] region_addr,
	input  logic [63:0] region_size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  outcome,
	output logic [6:0]  slot,
	output logic [6:0]  entries_held
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// Control: busy_q marks the commit cycle of the item in flight.
	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	region_t          key_q;
	logic             out_valid_q;
	logic [1:0]       outcome_q;
	logic [6:0]       slot_q;
	logic [6:0]       held_q;

	logic    accept;
	region_t key;

	// Cell row wiring; index 0 sees a virtual left neighbor that is below.
	srti_ctl_t              ctl      [TABLE_DEPTH];
	region_t                cell_reg [TABLE_DEPTH];
	logic [TABLE_DEPTH:0]   below_chain;
	logic [TABLE_DEPTH-1:0] boundary;
	logic [TABLE_DEPTH-1:0] hit;

	logic             dup;
	logic             full;
	logic             do_ins;
	logic [IDX_W-1:0] pos;
	logic [CNT_W-1:0] cnt_next;
	logic [IDX_W+6:0] pos_ext;
	logic [CNT_W+6:0] cnt_ext;

	// Item enters only with the row idle and the result register free.
	assign in_stall = busy_q || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	// Compare uses the incoming item; commit uses the held copy.
	always_comb begin
		if (busy_q) begin
			key = key_q;
		end else begin
			key.addr = region_addr;
			key.size = region_size;
		end
	end

	assign below_chain[0] = 1'b1;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		assign ctl[i].cmp   = accept;
		assign ctl[i].ins   = do_ins;
		assign ctl[i].valid = (CNT_W'(i) < cnt_q);

		srti_cell u_cell (
			.clk         (clk),
			.ctl         (ctl[i]),
			.key         (key),
			.left_region ((i == 0) ? key : cell_reg[(i == 0) ? 0 : i - 1]),
			.left_below  (below_chain[i]),
			.region      (cell_reg[i]),
			.below       (below_chain[i + 1]),
			.boundary    (boundary[i]),
			.hit         (hit[i])
		);
	end

	// Boundary is one-hot (or empty when a full row is all below the key).
	always_comb begin
		pos = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (boundary[i]) begin
				pos = pos | IDX_W'(i);
			end
		end
	end

	assign dup      = |hit;
	assign full     = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign do_ins   = busy_q && !dup && !full;
	assign cnt_next = do_ins ? cnt_q + CNT_W'(1) : cnt_q;
	assign pos_ext  = {7'd0, pos};
	assign cnt_ext  = {7'd0, cnt_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			busy_q <= accept;
			cnt_q  <= cnt_next;
			if (busy_q) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q.addr <= region_addr;
			key_q.size <= region_size;
		end
		if (busy_q) begin
			priority if (dup) begin
				outcome_q <= OUTCOME_DUPLICATE;
				slot_q    <= pos_ext[6:0];
			end else if (full) begin
				outcome_q <= OUTCOME_FULL;
				slot_q    <= 7'd0;
			end else begin
				outcome_q <= OUTCOME_INSERTED;
				slot_q    <= pos_ext[6:0];
			end
			held_q <= cnt_ext[6:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign outcome      = outcome_q;
	assign slot         = slot_q;
	assign entries_held = held_q;

	// Checks
	`SRTI_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(TABLE_DEPTH), "fill count over depth")
	`SRTI_ASSERT_NEXT(a_commit_one, clk, arst_n, busy_q, !busy_q && out_valid, "commit not single cycle")
	`SRTI_ASSERT(a_bound_onehot, clk, arst_n, !busy_q || $onehot0(boundary), "insert slot not unique")
	`SRTI_ASSERT_NEXT(a_full_hold, clk, arst_n, busy_q && full, $stable(cnt_q), "count moved when full")

endmodule

// ===== rtl/srti_cell.sv =====
// ----------------------------------------------------------------------------
// srti_cell: one entry of the sorted region row
// Compares its entry with the key, then keeps, loads or takes the left entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srti_cell
	import srti_pkg::*;
(
	input  logic      clk,
	input  srti_ctl_t ctl,
	input  region_t   key,
	input  region_t   left_region,
	input  logic      left_below,
	output region_t   region,
	output logic      below,
	output logic      boundary,
	output logic      hit
);

	region_t entry_q;
	logic    below_s1;
	logic    eq_s1;
	logic    lt_now;

	assign lt_now = (entry_q.addr < key.addr) ||
		((entry_q.addr == key.addr) && (entry_q.size < key.size));

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			below_s1 <= ctl.valid && lt_now;
			eq_s1    <= ctl.valid && (entry_q == key);
		end
		if (ctl.ins && !below_s1) begin
			entry_q <= left_below ? key : left_region;
		end
	end

	assign region   = entry_q;
	assign below    = below_s1;
	assign boundary = !below_s1 && left_below;
	assign hit      = boundary && eq_s1;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the sorted region table
// A short table of directed regions covers field extremes, ties on address,
// zero lengths and repeats. Random regions follow: they fill the table, then
// keep hitting it with repeats and drops once it is full. Every result is
// checked against an in-order model of the table, or against a hand-written
// result for typed rows. Both handshake sides pause at random.
// ----------------------------------------------------------------------------

module tb;
	import srti_pkg::*;

	localparam int          DEPTH      = DEPTH_DEF;
	localparam int          N_DIR      = 20;
	localparam int          N_RANDOM   = 1180;
	localparam int          IDLE_LIMIT = 1000;   // cycles with no handshake at all
	localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] TOP_BIT    = 64'h8000_0000_0000_0000;

	// One result of the table, as the output ports carry it.
	typedef struct packed {
		logic [1:0] outcome;
		logic [6:0] slot;
		logic [6:0] entries;
	} table_result_t;

	// Directed row; typed rows carry a hand-written result.
	typedef struct {
		logic [63:0]   addr;
		logic [63:0]   size;
		bit            typed;
		table_result_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] region_addr;
	logic [63:0] region_size;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  outcome;
	logic [6:0]  slot;
	logic [6:0]  entries_held;

	// Model of the table contents, advanced at each accepted item.
	logic [63:0] held_addr [DEPTH];
	logic [63:0] held_size [DEPTH];
	int          held_count;

	table_result_t pending [$];   // results still owed by the block, oldest first
	table_result_t want;
	int            error_count;
	int            sent;
	int            idle_cycles;

	// Typed rows insert (0,0) and (MAX,MAX), then repeat both.
	dir_row_t dir_rows [N_DIR] = '{
		'{64'h0,      64'h0,      1'b1, '{OUTCOME_INSERTED,  7'd0, 7'd1}},
		'{ALL_ONES,   ALL_ONES,   1'b1, '{OUTCOME_INSERTED,  7'd1, 7'd2}},
		'{64'h0,      64'h0,      1'b1, '{OUTCOME_DUPLICATE, 7'd0, 7'd2}},
		'{ALL_ONES,   ALL_ONES,   1'b1, '{OUTCOME_DUPLICATE, 7'd1, 7'd2}},
		'{64'h0,      ALL_ONES,   1'b0, '{OUTCOME_INSERTED,  7'd0, 7'd0}},
		'{ALL_ONES,   64'h0,      1'b0, '{OUTCOME_INSERTED,  7'd0, 7'd0}},
		'{64'h1000,   64'h10,     1'b0, '{OUTCOME_INSERTED,  7'd0, 7'd0}},
		'{64'h1000,   64'h8,      1'b0, '{OUTCOME_INSERTED,  7'd0, 7'd0}},
		'{64'h1000,   64'h20,     1'b0, '{OUTCOME_INSERTED,  7'd0, 7'd0}},
		'{64'h1000,   64'h10,     1'b0, '{OUTCOME_INSERTED,  7'd0, 7'd0}},
		'{TOP_BIT,    64'h1,      1'b0, '{OUTCOME_INSERTED,  7'd0, 7'd0}},
		'{~TOP_BIT,   ALL_ONES,   1'b0, '{OUTCOME_INSERTED,  7'd0, 7'd0}},
		'{64'h1,      64'h0,      1'b0, '{OUTCOME_INSERTED,  7'd0, 7'd0}},
		'{64'h0,      64'h1,      1'b0, '{OUTCOME_INSERTED,  7'd0, 7'd0}},
		'{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0,
			'{OUTCOME_INSERTED, 7'd0, 7'd0}},
		'{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0,
			'{OUTCOME_INSERTED, 7'd0, 7'd0}},
		'{64'h1000,   64'h0,      1'b0, '{OUTCOME_INSERTED,  7'd0, 7'd0}},
		'{64'h0,      64'h0,      1'b0, '{OUTCOME_INSERTED,  7'd0, 7'd0}},
		'{ALL_ONES,   TOP_BIT,    1'b0, '{OUTCOME_INSERTED,  7'd0, 7'd0}},
		'{ALL_ONES - 64'h1, ALL_ONES, 1'b0, '{OUTCOME_INSERTED, 7'd0, 7'd0}}
	};

	sorted_region_table_insert uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.region_addr  (region_addr),
		.region_size  (region_size),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.outcome      (outcome),
		.slot         (slot),
		.entries_held (entries_held)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Lower bound over (addr, size), both unsigned. A region equal to the
	// one at the bound is a repeat and changes nothing; the repeat check wins
	// over the full check. Otherwise insert there and shift the rest up.
	function automatic table_result_t insert_region(input logic [63:0] a, input logic [63:0] s);
		table_result_t r;
		int            pos;
		int            i;
		pos = 0;
		for (i = 0; i < held_count; i++) begin
			if (held_addr[i] < a || (held_addr[i] == a && held_size[i] < s))
				pos = i + 1;
		end
		if (pos < held_count && held_addr[pos] == a && held_size[pos] == s) begin
			r.outcome = OUTCOME_DUPLICATE;
			r.slot    = 7'(pos);
		end else if (held_count >= DEPTH) begin
			r.outcome = OUTCOME_FULL;   // dropped, slot reads zero
			r.slot    = 7'd0;
		end else begin
			for (i = held_count; i > pos; i--) begin
				held_addr[i] = held_addr[i - 1];
				held_size[i] = held_size[i - 1];
			end
			held_addr[pos] = a;
			held_size[pos] = s;
			held_count++;
			r.outcome = OUTCOME_INSERTED;
			r.slot    = 7'(pos);
		end
		r.entries = 7'(held_count);
		return r;
	endfunction

	// Mix of a small stepped pool (forces ties), extremes and full-width noise.
	function automatic logic [63:0] draw_field(input logic [63:0] step);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			return step * $urandom_range(0, 7);
		if (pick < 35) begin
			case ($urandom_range(0, 3))
				0: return 64'h0;
				1: return ALL_ONES;
				2: return TOP_BIT;
				default: return ~TOP_BIT;
			endcase
		end
		return {$urandom, $urandom};
	endfunction

	task automatic report(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		error_count++;
	endtask

	// Drive one region at the falling edge, hold it until taken, then log
	// the owed result. Every fourth block of 100 items runs with no gaps.
	task automatic send_region(input logic [63:0] a, input logic [63:0] s,
			input bit typed, input table_result_t fixed);
		int            gap;
		table_result_t predicted;
		gap = (((sent / 100) % 4) == 3) ? 0 : $urandom_range(0, 4);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		region_addr <= a;
		region_size <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = insert_region(a, s);
		if (typed)
			predicted = fixed;
		pending = {pending, predicted};
		sent++;
	endtask

	// Stimulus: directed rows, then random regions. Repeats are drawn from
	// the held entries; past full, half the items are repeats, half drops.
	initial begin
		int          k;
		int          idx;
		int          repeat_pct;
		logic [63:0] a;
		logic [63:0] s;
		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		region_addr = '0;
		region_size = '0;
		out_stall   = 1'b0;
		held_count  = 0;
		error_count = 0;
		sent        = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < N_DIR; k++)
			send_region(dir_rows[k].addr, dir_rows[k].size, dir_rows[k].typed, dir_rows[k].want);

		for (k = 0; k < N_RANDOM; k++) begin
			repeat_pct = (held_count >= DEPTH) ? 50 : 25;
			if (held_count > 0 && $urandom_range(0, 99) < repeat_pct) begin
				idx = $urandom_range(0, held_count - 1);
				a   = held_addr[idx];
				s   = held_size[idx];
			end else begin
				a = draw_field(64'h1000);
				s = draw_field(64'h1);
			end
			send_region(a, s, 1'b0, '0);
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// Drain, then wait for anything unexpected.
		while (pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Result side stall: drawn per result; every fourth block of 100 has none.
	initial begin
		int n;
		int got;
		got = 0;
		@(posedge arst_n);
		forever begin
			n = (((got / 100) % 4) == 1) ? 0 : $urandom_range(0, 4);
			repeat (n) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			got++;
		end
	end

	// Compare each taken result with the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				report($sformatf("unexpected result outcome=%0d slot=%0d entries=%0d",
					outcome, slot, entries_held));
			end else begin
				want = pending.pop_front();
				if (outcome !== want.outcome)
					report($sformatf("outcome %0d, want %0d", outcome, want.outcome));
				if (slot !== want.slot)
					report($sformatf("slot %0d, want %0d", slot, want.slot));
				if (entries_held !== want.entries)
					report($sformatf("entries_held %0d, want %0d", entries_held, want.entries));
			end
		end
	end

	// Watchdog on handshake activity.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/srti_pkg.sv
rtl/srti_cell.sv
rtl/sorted_region_table_insert.sv
dv/tb.sv
